// ===== rtl/vgapal_pkg.sv =====
// Shared types and codes for the VGA palette DAC register block.
// Used by the controller, the datapath and the top level; depends on nothing.
package vgapal_pkg;

    // Access kind carried in the lowest tuser bit
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register port selector
    typedef enum logic [1:0] {
        PORT_MASK = 2'd0,
        PORT_RIDX = 2'd1,
        PORT_WIDX = 2'd2,
        PORT_DATA = 2'd3
    } t_port;

    // Colour component sequence of the data port
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;        // input transfer this cycle
        logic fetch_done;  // palette read data is ready to be returned
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register empty or being drained
        logic data_rd;     // offered item is a data port read
    } t_dp_status;

endpackage

// ===== rtl/vga_palette_dac_registers.sv =====
// Top level of the VGA palette DAC register block.
// Joins vgapal_ctrl and vgapal_dp; depends on vgapal_pkg.
//
// Usage:
//   Each slave-side transfer is one byte-port access: tuser carries the
//   access kind and the port, tdata the byte written. Every access gives
//   exactly one master-side transfer whose tdata is the byte read back
//   (zero for writes).
//   Every access but a data port read gives its result from the output
//   register; a data port read first passes the registered palette RAM
//   read. Throughput is one access a cycle while the receiver takes the
//   results; no new access is taken while a data port read is in flight.
//   Reset clears the indices, the colour sequence and the valid bit of every
//   palette entry, so the palette reads as zero; the pixel mask resets to
//   all ones. There is no clearing pass.
//   When the receiver stalls, the result waits in the output register and
//   s_axis_tready drops until that result is taken; the next access may be
//   accepted in the same cycle as the result is taken.
module vga_palette_dac_registers #(
    parameter int ENTRIES        = 256,
    parameter int COMPONENT_BITS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] write_data
    input  logic [2:0] s_axis_tuser,   // [0] op, [2:1] port
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] read_data
);
    import vgapal_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    vgapal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vgapal_dp #(
        .ENTRIES        (ENTRIES),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (s_axis_tuser[0]),
        .i_port      (t_port'(s_axis_tuser[2:1])),
        .i_wdata     (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // A data read stalls input during the palette lookup, then presents a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_READ)
            && (s_axis_tuser[2:1] == PORT_DATA))
        |=> (!s_axis_tready ##1 m_axis_tvalid))
        else $error("data read did not return after the palette lookup");

    // Every write transfer yields a zero result in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_WRITE))
        |=> (m_axis_tvalid && (m_axis_tdata == 8'd0)))
        else $error("write transfer did not give a zero result");

    // No new access while a result is stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a result is stalled");

endmodule

// ===== rtl/vgapal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the palette entries.
module vgapal_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vgapal_ctrl.sv =====
// Sequencing controller for the palette DAC: accepts accesses and waits out
// the palette read latency. Depends on vgapal_pkg.
module vgapal_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  vgapal_pkg::t_dp_status i_status,
    output vgapal_pkg::t_dp_cmd    o_cmd
);
    import vgapal_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Accept only with a free output register and no read in flight
    assign o_in_ready       = (r_state == S_IDLE) && i_status.out_free;
    assign o_cmd.take       = i_in_valid && o_in_ready;
    assign o_cmd.fetch_done = (r_state == S_FETCH);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take && i_status.data_rd) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/vgapal_dp.sv =====
// Datapath of the palette DAC: index registers, component sequencing,
// palette RAM with valid bits and the output register.
// Depends on vgapal_pkg and vgapal_ram.
module vgapal_dp #(
    parameter int ENTRIES        = 256,
    parameter int COMPONENT_BITS = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  vgapal_pkg::t_dp_cmd    i_cmd,
    output vgapal_pkg::t_dp_status o_status,
    input  logic                   i_op,
    input  vgapal_pkg::t_port      i_port,
    input  logic [7:0]             i_wdata,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_out_data
);
    import vgapal_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ENTRY_W = 3 * COMPONENT_BITS;
    // Rounded-up reciprocal of ENTRIES in 16 fractional bits
    localparam int RECIP   = (65536 + ENTRIES - 1) / ENTRIES;

    // Reduce an 8-bit index modulo ENTRIES by reciprocal multiplication;
    // the quotient is exact for every byte value
    function automatic logic [IDX_W-1:0] f_wrap(input logic [7:0] v);
        logic [23:0] prod;
        logic [7:0]  quo;
        logic [15:0] rem;
        prod = 24'(v) * 24'(RECIP);
        quo  = prod[23:16];
        rem  = 16'(v) - 16'(quo) * 16'(ENTRIES);
        return rem[IDX_W-1:0];
    endfunction

    // Advance an index, wrapping at the top of the palette
    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        if (p == IDX_W'(ENTRIES - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    logic [IDX_W-1:0]          r_wr_ptr,   n_wr_ptr;
    logic [IDX_W-1:0]          r_rd_ptr,   n_rd_ptr;
    logic [1:0]                r_wr_phase, n_wr_phase;
    logic [1:0]                r_rd_phase, n_rd_phase;
    logic [COMPONENT_BITS-1:0] r_red,      n_red;
    logic [COMPONENT_BITS-1:0] r_green,    n_green;
    logic [7:0]                r_mask,     n_mask;
    logic [ENTRIES-1:0]        r_valid,    n_valid;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_out_data,  n_out_data;

    logic                      ram_we;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic [ENTRY_W-1:0]        entry;
    logic [COMPONENT_BITS-1:0] comp_in;

    assign comp_in   = i_wdata[COMPONENT_BITS-1:0];
    assign ram_wdata = {r_red, r_green, comp_in};

    // Entries never written read as zero
    assign entry = r_valid[r_rd_ptr] ? ram_rdata : '0;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.data_rd  = (i_op == OP_READ) && (i_port == PORT_DATA);

    vgapal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Register updates for each transfer and for the palette read return
    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_wr_phase  = r_wr_phase;
        n_rd_phase  = r_rd_phase;
        n_red       = r_red;
        n_green     = r_green;
        n_mask      = r_mask;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;

        if (i_cmd.take && (i_op == OP_WRITE)) begin
            n_out_valid = 1'b1;
            n_out_data  = 8'd0;
            unique case (i_port)
                PORT_MASK: n_mask = i_wdata;
                PORT_RIDX: begin
                    n_rd_ptr   = f_wrap(i_wdata);
                    n_rd_phase = PH_RED;
                end
                PORT_WIDX: begin
                    n_wr_ptr   = f_wrap(i_wdata);
                    n_wr_phase = PH_RED;
                end
                PORT_DATA: begin
                    unique case (r_wr_phase)
                        PH_RED: begin
                            n_red      = comp_in;
                            n_wr_phase = PH_GREEN;
                        end
                        PH_GREEN: begin
                            n_green    = comp_in;
                            n_wr_phase = PH_BLUE;
                        end
                        default: begin
                            ram_we             = 1'b1;
                            n_valid[r_wr_ptr]  = 1'b1;
                            n_wr_phase         = PH_RED;
                            n_wr_ptr           = f_next(r_wr_ptr);
                        end
                    endcase
                end
                default: n_mask = r_mask;
            endcase
        end else if (i_cmd.take) begin
            // Data port reads return after the palette lookup, in the fetch state
            unique case (i_port)
                PORT_MASK: begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_mask;
                end
                PORT_RIDX: begin
                    n_out_valid = 1'b1;
                    n_out_data  = 8'd0;
                end
                PORT_WIDX: begin
                    n_out_valid = 1'b1;
                    n_out_data  = 8'(r_wr_ptr);
                end
                default: n_out_data = r_out_data;
            endcase
        end

        // Return one component of the fetched entry
        if (i_cmd.fetch_done) begin
            n_out_valid = 1'b1;
            unique case (r_rd_phase)
                PH_RED: begin
                    n_out_data = 8'(entry[ENTRY_W-1:2*COMPONENT_BITS]);
                    n_rd_phase = PH_GREEN;
                end
                PH_GREEN: begin
                    n_out_data = 8'(entry[2*COMPONENT_BITS-1:COMPONENT_BITS]);
                    n_rd_phase = PH_BLUE;
                end
                default: begin
                    n_out_data = 8'(entry[COMPONENT_BITS-1:0]);
                    n_rd_phase = PH_RED;
                    n_rd_ptr   = f_next(r_rd_ptr);
                end
            endcase
        end
    end

    // Hold control state; output data needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_wr_phase  <= PH_RED;
            r_rd_phase  <= PH_RED;
            r_red       <= '0;
            r_green     <= '0;
            r_mask      <= 8'hFF;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_phase  <= n_wr_phase;
            r_rd_phase  <= n_rd_phase;
            r_red       <= n_red;
            r_green     <= n_green;
            r_mask      <= n_mask;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for vga_palette_dac_registers: byte-port accesses in, read-back bytes out.
// Depends on vgapal_pkg and the RTL of the block; predicts each read-back in a shadow of the DAC state.
module tb;
    import vgapal_pkg::*;

    localparam int ENTRIES     = 256;
    localparam int CBITS       = 6;
    localparam int RAND_ITEMS  = 1400;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic       op;
        t_port      port;
        logic [7:0] data;
    } t_access;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] write_data
    logic [2:0] s_axis_tuser  = 3'b000;  // [0] op, [2:1] port
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] read_data

    // Shadow of the DAC state
    logic [3*CBITS-1:0] pal_shadow [ENTRIES];
    logic [7:0]         wr_idx_sh, rd_idx_sh, mask_sh;
    logic [1:0]         wr_ph_sh, rd_ph_sh;
    logic [CBITS-1:0]   red_sh, green_sh;

    t_access    access_q [$];
    logic [7:0] readback_q [$];
    t_access    cur_acc;

    int n_total = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_pal_stores = 0;
    int n_pal_reads = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int long_hold_cnt = 0;
    int stall_cycles = 0;
    bit long_hold_done = 1'b0;
    bit idle_ok;

    vga_palette_dac_registers #(
        .ENTRIES        (ENTRIES),
        .COMPONENT_BITS (CBITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Idle in windows, and never over the closing stretch of the run
    assign idle_ok = (n_sent + 150 < n_total) && ((n_sent / 180) % 4 != 3);

    // Apply one access to the shadow state and return the byte it reads back
    function automatic logic [7:0] dac_access(t_access a);
        logic [3*CBITS-1:0] entry;
        logic [7:0]         rd;
        rd = 8'h00;
        if (a.op == OP_WRITE) begin
            case (a.port)
                PORT_MASK: mask_sh = a.data;
                PORT_RIDX: begin
                    rd_idx_sh = 8'(a.data % ENTRIES);
                    rd_ph_sh  = PH_RED;
                end
                PORT_WIDX: begin
                    wr_idx_sh = 8'(a.data % ENTRIES);
                    wr_ph_sh  = PH_RED;
                end
                default: begin
                    case (wr_ph_sh)
                        PH_RED: begin
                            red_sh   = a.data[CBITS-1:0];
                            wr_ph_sh = PH_GREEN;
                        end
                        PH_GREEN: begin
                            green_sh = a.data[CBITS-1:0];
                            wr_ph_sh = PH_BLUE;
                        end
                        default: begin
                            pal_shadow[wr_idx_sh] = {red_sh, green_sh, a.data[CBITS-1:0]};
                            wr_ph_sh  = PH_RED;
                            wr_idx_sh = 8'((wr_idx_sh + 1) % ENTRIES);
                            n_pal_stores++;
                        end
                    endcase
                end
            endcase
        end else begin
            case (a.port)
                PORT_MASK: rd = mask_sh;
                PORT_RIDX: rd = 8'h00;
                PORT_WIDX: rd = wr_idx_sh;
                default: begin
                    entry = pal_shadow[rd_idx_sh];
                    n_pal_reads++;
                    case (rd_ph_sh)
                        PH_RED: begin
                            rd       = 8'(entry[3*CBITS-1:2*CBITS]);
                            rd_ph_sh = PH_GREEN;
                        end
                        PH_GREEN: begin
                            rd       = 8'(entry[2*CBITS-1:CBITS]);
                            rd_ph_sh = PH_BLUE;
                        end
                        default: begin
                            rd        = 8'(entry[CBITS-1:0]);
                            rd_ph_sh  = PH_RED;
                            rd_idx_sh = 8'((rd_idx_sh + 1) % ENTRIES);
                        end
                    endcase
                end
            endcase
        end
        return rd;
    endfunction

    task automatic queue_access(logic op, t_port port, logic [7:0] data);
        t_access a;
        a.op   = op;
        a.port = port;
        a.data = data;
        access_q.push_back(a);
    endtask

    // Pick a palette index, mostly from a small window so reads find stored entries
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 15));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: offer queued accesses, hold each until its transfer, gap at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                readback_q.push_back(dac_access(cur_acc));
                n_sent <= n_sent + 1;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_ok && long_hold_cnt == 0 && $urandom_range(0, 19) == 0) begin
                    tx_gap <= $urandom_range(0, 18);
                    s_axis_tvalid <= 1'b0;
                end else if (access_q.size() != 0) begin
                    cur_acc = access_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_acc.data;
                    s_axis_tuser  <= {cur_acc.port, cur_acc.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold_cnt != 0) begin
            long_hold_cnt <= long_hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && n_sent >= n_total / 3) begin
            long_hold_done <= 1'b1;
            long_hold_cnt  <= LONG_HOLD;
            m_axis_tready  <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 19) == 0) begin
            rx_gap <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check the transfer due at the next rising edge against the oldest prediction
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (readback_q.size() == 0) begin
                $display("%0t: unexpected result, expected none got %02h", $time, m_axis_tdata);
                n_errors++;
            end else begin
                if (m_axis_tdata !== readback_q[0]) begin
                    $display("%0t: read_data mismatch, expected %02h got %02h",
                             $time, readback_q[0], m_axis_tdata);
                    n_errors++;
                end
                void'(readback_q.pop_front());
                n_checked++;
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("[vga_palette_dac_registers] ERROR");
            $finish;
        end
    end

    // Build the stimulus, run it and report
    initial begin
        int kind;
        int n;
        int i;
        for (i = 0; i < ENTRIES; i++)
            pal_shadow[i] = '0;
        wr_idx_sh = 8'h00;
        rd_idx_sh = 8'h00;
        wr_ph_sh  = PH_RED;
        rd_ph_sh  = PH_RED;
        red_sh    = '0;
        green_sh  = '0;
        mask_sh   = 8'hFF;

        // Directed: reset values, mask and index ports, wide data bytes, index wrap
        queue_access(OP_READ,  PORT_MASK, 8'h00);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_WRITE, PORT_MASK, 8'h00);
        queue_access(OP_READ,  PORT_MASK, 8'h00);
        queue_access(OP_WRITE, PORT_MASK, 8'hA5);
        queue_access(OP_READ,  PORT_MASK, 8'hFF);
        queue_access(OP_READ,  PORT_RIDX, 8'h00);
        queue_access(OP_WRITE, PORT_WIDX, 8'hFF);
        queue_access(OP_READ,  PORT_WIDX, 8'h00);
        queue_access(OP_WRITE, PORT_DATA, 8'hFF);
        queue_access(OP_WRITE, PORT_DATA, 8'hC0);
        queue_access(OP_WRITE, PORT_DATA, 8'h6A);
        queue_access(OP_READ,  PORT_WIDX, 8'h00);
        queue_access(OP_WRITE, PORT_DATA, 8'h15);
        queue_access(OP_WRITE, PORT_WIDX, 8'h01);
        queue_access(OP_WRITE, PORT_RIDX, 8'hFF);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_WRITE, PORT_RIDX, 8'hFF);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_READ,  PORT_DATA, 8'h00);
        queue_access(OP_WRITE, PORT_MASK, 8'h5A);

        // Random: mostly well-formed write and read sequences, some cut short, some noise
        while (access_q.size() < RAND_ITEMS + 25) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                queue_access(OP_WRITE, PORT_WIDX, pick_index());
                n = 3 * $urandom_range(1, 4);
                if ($urandom_range(0, 5) == 0)
                    n = n - $urandom_range(1, 2);
                repeat (n) queue_access(OP_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
            end else if (kind <= 6) begin
                queue_access(OP_WRITE, PORT_RIDX, pick_index());
                n = 3 * $urandom_range(1, 4);
                if ($urandom_range(0, 5) == 0)
                    n = n - $urandom_range(1, 2);
                repeat (n) queue_access(OP_READ, PORT_DATA, 8'($urandom_range(0, 255)));
            end else if (kind == 7) begin
                queue_access(OP_WRITE, PORT_MASK, 8'($urandom_range(0, 255)));
                queue_access(OP_READ,  PORT_MASK, 8'($urandom_range(0, 255)));
            end else if (kind == 8) begin
                queue_access(OP_READ, PORT_WIDX, 8'($urandom_range(0, 255)));
                queue_access(OP_READ, PORT_RIDX, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_access(1'($urandom_range(0, 1)), t_port'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)));
            end
        end
        n_total = access_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every access sent and every result checked, then a short settle
        while (n_sent < n_total || readback_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (readback_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, readback_q.size());
            n_errors++;
        end

        $display("Run covered %0d accesses and %0d checked results, %0d mismatches.",
                 n_sent, n_checked, n_errors);
        $display("Palette entries stored: %0d, palette component reads: %0d.",
                 n_pal_stores, n_pal_reads);
        if (n_errors == 0)
            $display("[vga_palette_dac_registers] OK");
        else
            $display("[vga_palette_dac_registers] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vgapal_pkg.sv
rtl/vgapal_ram.sv
rtl/vgapal_ctrl.sv
rtl/vgapal_dp.sv
rtl/vga_palette_dac_registers.sv
tb/sv/tb.sv
